/* rtl/tccc_pkg.sv */
// Package for the text console cursor controller.
// Holds the action codes, character constants, register indexes and the queue record.
// No dependencies.
package tccc_pkg;

  localparam int BYTE_W  = 8;
  localparam int ACT_W   = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [ACT_W-1:0] ACT_SERIAL = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DRAW   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SCROLL = 2'd2;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_ROWS    = 2'd1;

  localparam logic OP_PUT   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [BYTE_W-1:0] CH_BS        = 8'd8;
  localparam logic [BYTE_W-1:0] CH_TAB       = 8'd9;
  localparam logic [BYTE_W-1:0] CH_NL        = 8'd10;
  localparam logic [BYTE_W-1:0] CH_SPACE     = 8'd32;
  localparam logic [BYTE_W-1:0] CH_PRINT_MIN = 8'd32;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_ECHO,
    CMD_BKSP
  } cmd_kind_t;

  // One classified item: the back end expands it into its actions.
  typedef struct packed {
    cmd_kind_t         kind;
    logic [BYTE_W-1:0] glyph;
    logic              scroll;
    logic              draw;
    logic [BYTE_W-1:0] col;
    logic [BYTE_W-1:0] row;
  } cmd_rec_t;

endpackage

/* rtl/tccc_in_if.sv */
// Input channel of the console cursor controller: opcode and character byte.
// Depends on tccc_pkg.
interface tccc_in_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [tccc_pkg::BYTE_W-1:0]  char_code;

  modport source (output valid, output opcode, output char_code, input ready);
  modport sink   (input valid, input opcode, input char_code, output ready);
endinterface

/* rtl/tccc_out_if.sv */
// Result channel of the console cursor controller: one or more actions per item.
// Depends on tccc_pkg.
interface tccc_out_if;
  logic                         valid;
  logic                         ready;
  logic [tccc_pkg::ACT_W-1:0]   action;
  logic [tccc_pkg::BYTE_W-1:0]  glyph_byte;
  logic [tccc_pkg::BYTE_W-1:0]  cell_column;
  logic [tccc_pkg::BYTE_W-1:0]  cell_row;
  logic                         last;

  modport source (output valid, output action, output glyph_byte, output cell_column,
                  output cell_row, output last, input ready);
  modport sink   (input valid, input action, input glyph_byte, input cell_column,
                  input cell_row, input last, output ready);
endinterface

/* rtl/tccc_cfg_if.sv */
// Configuration write channel of the console cursor controller.
// Depends on tccc_pkg.
interface tccc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tccc_pkg::CFG_IDX_W-1:0]  index;
  logic [tccc_pkg::BYTE_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/text_console_cursor_controller_core.sv */
// Text console cursor controller: put-character and clear items in, cell actions out.
// The first action of an item reaches the output register after the item has passed the command queue.
// Throughput: one item per cycle at the input while the command queue has room;
// the output gives one action per cycle while ready; an item gives 1 to 4 actions (tab: none).
// Reset (rst_n low, synchronous) zeroes the screen size, the cursor, the queue and output valid.
module text_console_cursor_controller_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  tccc_in_if.sink     in_chan,
  tccc_cfg_if.sink    cfg_chan,
  tccc_out_if.source  out_chan
);
  import tccc_pkg::*;

  logic     q_full, q_push, q_pop, q_valid;
  cmd_rec_t push_rec, head_rec;

  tccc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .cfg_chan (cfg_chan),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_rec    (push_rec)
  );

  tccc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_rec   (push_rec),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_rec   (head_rec)
  );

  tccc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_rec    (head_rec),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

/* rtl/tccc_front.sv */
// Front end: holds the screen size registers and the cursor, classifies each item and pushes
// one command record into the queue for every item but a tab. Depends on tccc_pkg and the channel interfaces.
module tccc_front (
  input  logic               clk,
  input  logic               rst_n,
  tccc_in_if.sink            in_chan,
  tccc_cfg_if.sink           cfg_chan,
  input  logic               q_full,
  output logic               q_push,
  output tccc_pkg::cmd_rec_t q_rec
);
  import tccc_pkg::*;

  logic [BYTE_W-1:0] cols_r, rows_r;
  logic [BYTE_W-1:0] col_r, col_nxt;
  logic [BYTE_W-1:0] row_r, row_nxt;

  logic              accept;
  logic              screen;
  logic              adv_scroll;
  logic [BYTE_W-1:0] adv_row;
  logic [BYTE_W-1:0] pc_col, pc_row;
  logic              wrap;
  logic [BYTE_W-1:0] ch;

  assign in_chan.ready  = !q_full;
  assign cfg_chan.ready = 1'b1;
  assign accept         = in_chan.valid && in_chan.ready;
  assign ch             = in_chan.char_code;
  assign screen         = (cols_r != '0) && (rows_r != '0);

  // line advance: scroll when the next row would be past the last one
  assign adv_scroll = ({1'b0, row_r} + 9'd1) >= {1'b0, rows_r};
  assign adv_row    = adv_scroll ? (rows_r - 8'd1) : (row_r + 8'd1);

  // printable: late wrap when the column has reached the column count
  assign wrap   = col_r >= cols_r;
  assign pc_col = wrap ? '0 : col_r;
  assign pc_row = wrap ? adv_row : row_r;

  always_comb begin
    col_nxt       = col_r;
    row_nxt       = row_r;
    q_push        = 1'b0;
    q_rec.kind    = CMD_ECHO;
    q_rec.glyph   = ch;
    q_rec.scroll  = 1'b0;
    q_rec.draw    = 1'b0;
    q_rec.col     = '0;
    q_rec.row     = '0;
    if (in_chan.opcode == OP_CLEAR) begin
      q_push     = accept;
      q_rec.kind = CMD_CLEAR;
      col_nxt    = '0;
      row_nxt    = '0;
    end else if (ch != CH_TAB) begin
      q_push = accept;
      if (ch == CH_BS) begin
        q_rec.kind = CMD_BKSP;
        if (screen) begin
          if (col_r != '0) begin
            col_nxt    = col_r - 8'd1;
            q_rec.draw = 1'b1;
          end else if (row_r != '0) begin
            row_nxt    = row_r - 8'd1;
            col_nxt    = cols_r - 8'd1;
            q_rec.draw = 1'b1;
          end
          q_rec.col = col_nxt;
          q_rec.row = row_nxt;
        end
      end else if (screen && ch == CH_NL) begin
        q_rec.scroll = adv_scroll;
        col_nxt      = '0;
        row_nxt      = adv_row;
      end else if (screen && ch >= CH_PRINT_MIN) begin
        q_rec.scroll = wrap && adv_scroll;
        q_rec.draw   = 1'b1;
        q_rec.col    = pc_col;
        q_rec.row    = pc_row;
        col_nxt      = pc_col + 8'd1;
        row_nxt      = pc_row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= '0;
      rows_r <= '0;
      col_r  <= '0;
      row_r  <= '0;
    end else begin
      if (cfg_chan.valid) begin
        if (cfg_chan.index == REG_TEXT_COLUMNS) begin
          cols_r <= cfg_chan.data;
        end else if (cfg_chan.index == REG_TEXT_ROWS) begin
          rows_r <= cfg_chan.data;
        end
      end
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

endmodule

/* rtl/tccc_queue.sv */
// Short command queue between front and back end.
// Depends on tccc_pkg for the record type.
module tccc_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tccc_pkg::cmd_rec_t push_rec,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output tccc_pkg::cmd_rec_t head_rec
);
  import tccc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_rec_t          slots_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  assign full       = count_r == CNT_W'(DEPTH);
  assign head_valid = count_r != '0;
  assign head_rec   = slots_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

/* rtl/tccc_back.sv */
// Back end: expands the command at the queue head into its actions, one per cycle unless
// the output stalls, into the output register. Depends on tccc_pkg and tccc_out_if.
module tccc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  tccc_pkg::cmd_rec_t q_rec,
  output logic               q_pop,
  tccc_out_if.source         out_chan
);
  import tccc_pkg::*;

  logic              out_valid_r;
  logic [ACT_W-1:0]  action_r;
  logic [BYTE_W-1:0] glyph_r, col_r, row_r;
  logic              last_r;
  logic [1:0]        step_r;

  logic              load;
  logic [2:0]        n_act;
  logic              is_last;
  logic [ACT_W-1:0]  act_c;
  logic [BYTE_W-1:0] glyph_c, col_c, row_c;

  assign load  = q_valid && (!out_valid_r || out_chan.ready);
  assign q_pop = load && is_last;

  always_comb begin
    unique case (q_rec.kind)
      CMD_CLEAR: n_act = 3'd1;
      CMD_BKSP:  n_act = 3'd3 + {2'b00, q_rec.draw};
      CMD_ECHO:  n_act = 3'd1 + {2'b00, q_rec.scroll} + {2'b00, q_rec.draw};
      default:   n_act = 3'd1;
    endcase
  end

  assign is_last = ({1'b0, step_r} + 3'd1) == n_act;

  always_comb begin
    act_c   = ACT_SERIAL;
    glyph_c = '0;
    col_c   = '0;
    row_c   = '0;
    unique case (q_rec.kind)
      CMD_CLEAR: begin
        act_c = ACT_CLEAR;
      end
      CMD_BKSP: begin
        if (step_r == 2'd3) begin
          act_c   = ACT_DRAW;
          glyph_c = CH_SPACE;
          col_c   = q_rec.col;
          row_c   = q_rec.row;
        end else begin
          glyph_c = (step_r == 2'd1) ? CH_SPACE : CH_BS;
        end
      end
      CMD_ECHO: begin
        if (step_r == 2'd0) begin
          glyph_c = q_rec.glyph;
        end else if (step_r == 2'd1 && q_rec.scroll) begin
          act_c = ACT_SCROLL;
        end else begin
          act_c   = ACT_DRAW;
          glyph_c = q_rec.glyph;
          col_c   = q_rec.col;
          row_c   = q_rec.row;
        end
      end
      default: begin
        act_c = ACT_SERIAL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      action_r <= act_c;
      glyph_r  <= glyph_c;
      col_r    <= col_c;
      row_r    <= row_c;
      last_r   <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        step_r      <= is_last ? 2'd0 : step_r + 2'd1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.action      = action_r;
  assign out_chan.glyph_byte  = glyph_r;
  assign out_chan.cell_column = col_r;
  assign out_chan.cell_row    = row_r;
  assign out_chan.last        = last_r;

`ifndef SYNTHESIS
  // a command in progress never leaves the queue head early
  a_step_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    step_r != 2'd0 |-> q_valid)
    else $error("back end mid-command without a queued command");

  // clear and scroll carry no glyph or cell
  a_plain_actions_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (action_r == ACT_CLEAR || action_r == ACT_SCROLL)
      |-> glyph_r == '0 && col_r == '0 && row_r == '0)
    else $error("scroll or clear with non-zero payload");

  // a clear is always the only action of its item
  a_clear_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && action_r == ACT_CLEAR |-> last_r)
    else $error("clear action not marked last");

  // a pop ends a run, so the next action starts from the first step
  a_pop_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> step_r == 2'd0)
    else $error("step counter not reset after pop");
`endif

endmodule
